// File: hdl/pcd_pkg.sv
package pcd_pkg;

    localparam int DIM_BITS     = 16;
    localparam int AREA_BITS    = 32;
    localparam int SIZE_ENTRIES = 25;
    localparam int QUEUE_DEPTH  = 2;

    localparam logic [DIM_BITS-1:0] SIZE_W [SIZE_ENTRIES] = '{
        16'd160,  16'd192,  16'd320,  16'd320,  16'd384,
        16'd640,  16'd640,  16'd640,  16'd640,  16'd640,
        16'd720,  16'd720,  16'd768,  16'd1024, 16'd1152,
        16'd1280, 16'd1280, 16'd1440, 16'd1536, 16'd1600,
        16'd1600, 16'd3072, 16'd3200, 16'd3400, 16'd4700
    };

    localparam logic [DIM_BITS-1:0] SIZE_H [SIZE_ENTRIES] = '{
        16'd120,  16'd128,  16'd200,  16'd240,  16'd256,
        16'd512,  16'd400,  16'd480,  16'd485,  16'd486,
        16'd485,  16'd486,  16'd512,  16'd768,  16'd900,
        16'd960,  16'd1024, 16'd972,  16'd1024, 16'd1200,
        16'd1280, 16'd2048, 16'd4000, 16'd4400, 16'd3300
    };

    // classification handed from front to back
    typedef struct packed {
        logic                nz;   // count is nonzero
        logic                hit;  // size table matched
        logic [DIM_BITS-1:0] w;
        logic [DIM_BITS-1:0] h;
    } t_class;

    // pixel area of a table entry; only called with constant indexes
    function automatic logic [AREA_BITS-1:0] size_area(input int idx);
        logic [AREA_BITS-1:0] a;
        logic [AREA_BITS-1:0] b;
        a = AREA_BITS'(SIZE_W[idx]);
        b = AREA_BITS'(SIZE_H[idx]);
        return a * b;
    endfunction

endpackage

// File: hdl/pcd_front.sv
module pcd_front #(
    parameter int COUNT_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [COUNT_BITS-1:0] i_count,
    input  logic                  i_q_full,
    output logic                  o_busy,
    output logic                  o_push,
    output logic [COUNT_BITS-1:0] o_count,
    output pcd_pkg::t_class       o_cls
);

    localparam int CMP_BITS = (COUNT_BITS > pcd_pkg::AREA_BITS) ? COUNT_BITS
                                                                : pcd_pkg::AREA_BITS;

    logic                  r_valid;
    logic                  n_valid;
    logic [COUNT_BITS-1:0] r_count;
    pcd_pkg::t_class       r_cls;
    pcd_pkg::t_class       n_cls;
    logic [CMP_BITS-1:0]   w_cmp;
    logic                  w_ready;
    logic                  w_accept;

    assign w_ready  = !r_valid || !i_q_full;
    assign w_accept = i_start && w_ready;
    assign o_busy   = !w_ready;
    assign o_push   = r_valid && !i_q_full;
    assign o_count  = r_count;
    assign o_cls    = r_cls;

    assign w_cmp = CMP_BITS'(i_count);

    // scan from the back so the first matching entry wins
    always_comb begin
        n_cls.nz  = (i_count != '0);
        n_cls.hit = 1'b0;
        n_cls.w   = '0;
        n_cls.h   = '0;
        for (int i = pcd_pkg::SIZE_ENTRIES - 1; i >= 0; i--) begin
            if (w_cmp == CMP_BITS'(pcd_pkg::size_area(i))) begin
                n_cls.hit = 1'b1;
                n_cls.w   = pcd_pkg::SIZE_W[i];
                n_cls.h   = pcd_pkg::SIZE_H[i];
            end
        end
    end

    always_comb begin
        n_valid = r_valid;
        if (w_accept) begin
            n_valid = 1'b1;
        end else if (o_push) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_count <= i_count;
            r_cls   <= n_cls;
        end
    end

endmodule

// File: hdl/pcd_queue.sv
module pcd_queue #(
    parameter int COUNT_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  logic [COUNT_BITS-1:0] i_count,
    input  pcd_pkg::t_class       i_cls,
    input  logic                  i_pop,
    output logic                  o_full,
    output logic                  o_valid,
    output logic [COUNT_BITS-1:0] o_count,
    output pcd_pkg::t_class       o_cls
);

    localparam int PTR_BITS = $clog2(pcd_pkg::QUEUE_DEPTH);
    localparam int CNT_BITS = $clog2(pcd_pkg::QUEUE_DEPTH + 1);

    logic [COUNT_BITS-1:0] r_count_mem [pcd_pkg::QUEUE_DEPTH];
    pcd_pkg::t_class       r_cls_mem   [pcd_pkg::QUEUE_DEPTH];
    logic [PTR_BITS-1:0]   r_wr_ptr;
    logic [PTR_BITS-1:0]   r_rd_ptr;
    logic [CNT_BITS-1:0]   r_fill;
    logic                  w_do_pop;

    assign o_full   = (r_fill == CNT_BITS'(pcd_pkg::QUEUE_DEPTH));
    assign o_valid  = (r_fill != '0);
    assign w_do_pop = i_pop && o_valid;
    assign o_count  = r_count_mem[r_rd_ptr];
    assign o_cls    = r_cls_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_BITS'(pcd_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                              : r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_BITS'(pcd_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                              : r_rd_ptr + 1'b1;
            end
            if (i_push && !w_do_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (!i_push && w_do_pop) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_count_mem[r_wr_ptr] <= i_count;
            r_cls_mem[r_wr_ptr]   <= i_cls;
        end
    end

endmodule

// File: hdl/pcd_sqrt.sv
module pcd_sqrt #(
    parameter int COUNT_BITS = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic [COUNT_BITS-1:0]           i_count,
    input  pcd_pkg::t_class                 i_cls,
    output logic                            o_valid,
    output logic                            o_found,
    output logic [pcd_pkg::DIM_BITS-1:0]    o_width,
    output logic [pcd_pkg::DIM_BITS-1:0]    o_height
);

    localparam int RB = (COUNT_BITS + 1) / 2;  // root bits, one per stage
    localparam int XB = 2 * RB;
    localparam int DB = pcd_pkg::DIM_BITS;

    logic            r_vld  [RB+1];
    logic [XB-1:0]   r_x    [RB+1];
    logic [RB:0]     r_rem  [RB+1];
    logic [RB-1:0]   r_root [RB+1];
    pcd_pkg::t_class r_cls  [RB+1];

    logic            r_out_valid;
    logic            r_out_found;
    logic [DB-1:0]   r_out_w;
    logic [DB-1:0]   r_out_h;

    logic            w_exact;
    logic            w_fits;
    logic            w_sq_found;
    logic [DB-1:0]   w_root16;

    // stage 0 takes the queue head
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x[0]    <= XB'(i_count);
        r_rem[0]  <= '0;
        r_root[0] <= '0;
        r_cls[0]  <= i_cls;
    end

    // one root bit per stage: bring down two count bits, trial subtract
    for (genvar k = 0; k < RB; k++) begin : g_stage
        logic [RB+2:0] n_rem_sh;
        logic [RB+2:0] n_trial;
        logic [RB+2:0] n_diff;
        logic          n_take;

        assign n_rem_sh = {r_rem[k], r_x[k][XB-1 -: 2]};
        assign n_trial  = {1'b0, r_root[k], 2'b01};
        assign n_diff   = n_rem_sh - n_trial;
        assign n_take   = (n_rem_sh >= n_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else begin
                r_vld[k+1] <= r_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_x[k+1]    <= {r_x[k][XB-3:0], 2'b00};
            r_rem[k+1]  <= n_take ? n_diff[RB:0] : n_rem_sh[RB:0];
            r_root[k+1] <= {r_root[k][RB-2:0], n_take};
            r_cls[k+1]  <= r_cls[k];
        end
    end

    if (RB > DB) begin : g_wide_root
        assign w_fits   = (r_root[RB][RB-1:DB] == '0);
        assign w_root16 = r_root[RB][DB-1:0];
    end else begin : g_narrow_root
        assign w_fits   = 1'b1;
        assign w_root16 = DB'(r_root[RB]);
    end

    assign w_exact    = (r_rem[RB] == '0);
    assign w_sq_found = r_cls[RB].nz && w_exact && w_fits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_vld[RB];
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_found <= r_cls[RB].hit || w_sq_found;
        if (r_cls[RB].hit) begin
            r_out_w <= r_cls[RB].w;
            r_out_h <= r_cls[RB].h;
        end else if (w_sq_found) begin
            r_out_w <= w_root16;
            r_out_h <= w_root16;
        end else begin
            r_out_w <= '0;
            r_out_h <= '0;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_found  = r_out_found;
    assign o_width  = r_out_w;
    assign o_height = r_out_h;

endmodule

// File: hdl/pixel_count_to_dimensions.sv
// Pixel count to image dimensions.
// Input channel: drive i_pixel_count with i_start high; the transfer happens
//   on a rising edge with i_start high and o_busy low. Only the low
//   COUNT_BITS bits of the count are used.
// Output channel: each result shows for one cycle with o_valid high:
//   o_found, o_img_width, o_img_height. Table sizes are checked first, in
//   order; otherwise an exact square root gives a square image. No match,
//   or a zero count, gives o_found low and zero dimensions.
// Throughput: one count per cycle, sustained. The square root is a pipeline
//   with one root bit per stage, so nothing loops back.
// Path: from transfer to strobe the count passes the front register, the
//   queue write, the stage 0 register, one stage per root bit and the
//   output register.
// Reset: i_rst_n, synchronous, active low, empties front, queue and
//   pipeline; o_valid is low and o_busy low right after.
// The receiver cannot stall: the back end advances every cycle, so the
//   queue drains at once and o_busy stays low in normal use.
module pixel_count_to_dimensions #(
    parameter int COUNT_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [31:0] i_pixel_count,
    output logic        o_valid,
    output logic        o_found,
    output logic [15:0] o_img_width,
    output logic [15:0] o_img_height
);

    logic [COUNT_BITS-1:0] w_count;       // input count, masked or zero-extended
    logic                  w_push;        // front -> queue transfer
    logic [COUNT_BITS-1:0] w_f_count;
    pcd_pkg::t_class       w_f_cls;
    logic                  w_q_full;
    logic                  w_q_valid;     // queue head present; back always takes it
    logic [COUNT_BITS-1:0] w_q_count;
    pcd_pkg::t_class       w_q_cls;

    // narrow datapath keeps the low bits; a wide one zero-extends
    if (COUNT_BITS <= 32) begin : g_mask
        assign w_count = i_pixel_count[COUNT_BITS-1:0];
    end else begin : g_extend
        assign w_count = COUNT_BITS'(i_pixel_count);
    end

    // front: take the count and match it against the size table
    pcd_front #(
        .COUNT_BITS(COUNT_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_count  (w_count),
        .i_q_full (w_q_full),
        .o_busy   (o_busy),
        .o_push   (w_push),
        .o_count  (w_f_count),
        .o_cls    (w_f_cls)
    );

    // short queue between the classifier and the root pipeline
    pcd_queue #(
        .COUNT_BITS(COUNT_BITS)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_count  (w_f_count),
        .i_cls    (w_f_cls),
        .i_pop    (w_q_valid),
        .o_full   (w_q_full),
        .o_valid  (w_q_valid),
        .o_count  (w_q_count),
        .o_cls    (w_q_cls)
    );

    // back: pipelined square root and final selection
    pcd_sqrt #(
        .COUNT_BITS(COUNT_BITS)
    ) u_sqrt (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_q_valid),
        .i_count  (w_q_count),
        .i_cls    (w_q_cls),
        .o_valid  (o_valid),
        .o_found  (o_found),
        .o_width  (o_img_width),
        .o_height (o_img_height)
    );

endmodule
